// ===== hdl/assert_macros.svh =====
// Shared assertion macros; every use samples on clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expr must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/clsr_pkg.sv =====
package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WARM_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(WARM_STEPS);
    localparam int VAL_W       = 31;

    localparam logic [31:0] MOD1        = 32'd2147483563;
    localparam logic [31:0] MOD2        = 32'd2147483399;
    localparam logic [15:0] MUL1        = 16'd40014;
    localparam logic [15:0] MUL2        = 16'd40692;
    localparam logic [30:0] SECOND_INIT = 31'd123456789;

    // 2^31 - m for the folding reduction
    localparam logic [8:0]  FOLD1 = 9'((64'd1 << 31) - 64'(MOD1));
    localparam logic [8:0]  FOLD2 = 9'((64'd1 << 31) - 64'(MOD2));

    localparam logic [31:0] MOD1_LESS = MOD1 - 32'd1;
    localparam logic [31:0] SLOT_DIV  = 32'(64'd1 + 64'(MOD1_LESS) / 64'(TABLE_DEPTH));
    // floor(2^31 / SLOT_DIV), for the slot estimate
    localparam logic [8:0]  SLOT_RCP  = 9'((64'd1 << 31) / 64'(SLOT_DIV));

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

endpackage

// ===== hdl/clsr_if.sv =====
interface clsr_cmd_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [30:0] seed_value;

    modport source (output valid, output op, output seed_value, input ready);
    modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface clsr_rnd_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// ===== hdl/clsr_ram.sv =====
module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/clsr_step.sv =====
`include "assert_macros.svh"

// Both generators advance one step: z * a mod m, two-stage.
module clsr_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] z1,
    input  logic [30:0] z2,
    output logic        done,
    output logic [30:0] z1_out,
    output logic [30:0] z2_out
);

    localparam logic [15:0] MUL1_W = clsr_pkg::MUL1;
    localparam logic [15:0] MUL2_W = clsr_pkg::MUL2;

    logic [46:0] p1_reg, p1_next;
    logic [46:0] p2_reg, p2_next;
    logic        v1_reg, v2_reg;
    logic [30:0] z1_reg, z1_next;
    logic [30:0] z2_reg, z2_next;
    logic [31:0] s1, s2;

    always_comb
    begin
        p1_next = {16'd0, z1} * {31'd0, MUL1_W};
        p2_next = {16'd0, z2} * {31'd0, MUL2_W};

        // x = hi*2^31 + lo == hi*(2^31-m) + lo (mod m), below 2m
        s1 = {16'd0, p1_reg[46:31]} * {23'd0, clsr_pkg::FOLD1} + {1'b0, p1_reg[30:0]};
        s2 = {16'd0, p2_reg[46:31]} * {23'd0, clsr_pkg::FOLD2} + {1'b0, p2_reg[30:0]};
        z1_next = (s1 >= clsr_pkg::MOD1) ? 31'(s1 - clsr_pkg::MOD1) : s1[30:0];
        z2_next = (s2 >= clsr_pkg::MOD2) ? 31'(s2 - clsr_pkg::MOD2) : s2[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            p1_reg <= '0;
            p2_reg <= '0;
            z1_reg <= '0;
            z2_reg <= '0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            z1_reg <= z1_next;
            z2_reg <= z2_next;
        end
    end

    assign done   = v2_reg;
    assign z1_out = z1_reg;
    assign z2_out = z2_reg;

    `ASSERT_ALWAYS(a_step_latency, v1_reg |=> v2_reg, "step result missing after product stage")
    `ASSERT_ALWAYS(a_step_reduced, v2_reg |-> ({1'b0, z1_reg} < clsr_pkg::MOD1 && {1'b0, z2_reg} < clsr_pkg::MOD2), "step result not reduced")

endmodule

// ===== hdl/clsr_div.sv =====
// Slot index = x / SLOT_DIV: reciprocal estimate, then one correction compare.
module clsr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [30:0]                x,
    output logic                       done,
    output logic [clsr_pkg::IDX_W-1:0] slot
);

    localparam int Q_W = clsr_pkg::IDX_W + 1;

    logic [39:0]    est_prod;
    logic [39:0]    bound;
    logic           ge;
    logic [30:0]    x_reg, x_next;
    logic [Q_W-1:0] est_reg, est_next;
    logic [Q_W-1:0] q_reg, q_next;
    logic           busy_reg;
    logic           done_reg;

    always_comb
    begin
        // estimate is the quotient or one below it
        est_prod = {9'd0, x} * {31'd0, clsr_pkg::SLOT_RCP};
        est_next = start ? Q_W'(est_prod[39:31]) : est_reg;
        x_next   = start ? x : x_reg;
        bound    = (40'(est_reg) + 40'd1) * {8'd0, clsr_pkg::SLOT_DIV};
        ge       = {9'd0, x_reg} >= bound;
        q_next   = busy_reg ? est_reg + Q_W'(ge) : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            est_reg  <= '0;
            q_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            est_reg  <= est_next;
            q_reg    <= q_next;
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    assign done = done_reg;
    // guard: saturate to the top slot
    assign slot = (32'(q_reg) >= 32'(clsr_pkg::TABLE_DEPTH))
                ? clsr_pkg::IDX_W'(clsr_pkg::TABLE_DEPTH - 1) : q_reg[clsr_pkg::IDX_W-1:0];

endmodule

// ===== hdl/combined_lcg_shuffle_rng_top.sv =====
// Combined two-generator congruential RNG (moduli 2147483563 and 2147483399) with a
// TABLE_DEPTH-entry shuffle table held in a single-port-style RAM. A draw item returns
// one integer in 1..2147483562; divide by 2147483563 for a fraction. A draw goes from
// accept through a launch state, the two-stage multiply-reduce step (the slot index is
// worked out alongside it in two stages), the table read, and the mix and write-back,
// then is ready again. A seed item, or any draw while the first generator is zero (as
// after reset), first runs TABLE_DEPTH+8 warm-up steps through the multiply-reduce unit.
// A new item is taken while a result still waits in the output register; the
// write-back of that next draw waits until the result is taken.
`include "assert_macros.svh"

module combined_lcg_shuffle_rng_top (
    input  logic        clk,
    input  logic        rst_n,
    clsr_cmd_if.sink    cmd,
    clsr_rnd_if.source  rnd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WARM,
        S_WARM_WAIT,
        S_DRAW,
        S_DRAW_WAIT,
        S_READ,
        S_MIX
    } state_t;

    state_t                     state_reg, state_next;
    logic [30:0]                first_reg, first_next;
    logic [30:0]                second_reg, second_next;
    logic [30:0]                last_reg, last_next;
    logic [clsr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [clsr_pkg::IDX_W-1:0] slot_reg, slot_next;
    logic                       got_step_reg, got_step_next;
    logic                       got_div_reg, got_div_next;
    logic                       out_valid_reg, out_valid_next;
    logic [30:0]                out_value_reg, out_value_next;

    logic                       step_start, step_done;
    logic [30:0]                step_z1, step_z2;
    logic                       div_start, div_done;
    logic [clsr_pkg::IDX_W-1:0] div_slot;

    logic                       ram_we, ram_re;
    logic [clsr_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
    logic [30:0]                ram_wdata, ram_rdata;

    logic [31:0]                diff, wrapped;
    logic [30:0]                mix_val;
    logic [30:0]                seed_val;

    clsr_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (step_start),
        .z1     (first_reg),
        .z2     (second_reg),
        .done   (step_done),
        .z1_out (step_z1),
        .z2_out (step_z2)
    );

    clsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (last_reg),
        .done  (div_done),
        .slot  (div_slot)
    );

    clsr_ram #(
        .WIDTH (clsr_pkg::VAL_W),
        .DEPTH (clsr_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        diff    = {1'b0, ram_rdata} - {1'b0, second_reg};
        wrapped = ($signed(diff) < 32'sd1) ? diff + clsr_pkg::MOD1_LESS : diff;
        mix_val = wrapped[30:0];
        seed_val = (cmd.op == clsr_pkg::OP_SEED && cmd.seed_value != 31'd0)
                 ? cmd.seed_value : 31'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        got_step_next  = got_step_reg;
        got_div_next   = got_div_reg;
        out_valid_next = out_valid_reg && !rnd.ready;
        out_value_next = out_value_reg;
        step_start     = 1'b0;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = slot_reg;
        ram_raddr      = slot_reg;
        ram_wdata      = first_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.op == clsr_pkg::OP_SEED || first_reg == 31'd0)
                    begin
                        first_next  = seed_val;
                        second_next = seed_val;
                        cnt_next    = clsr_pkg::CNT_W'(clsr_pkg::WARM_STEPS - 1);
                        state_next  = S_WARM;
                    end
                    else
                    begin
                        state_next = S_DRAW;
                    end
                end
            end
            S_WARM:
            begin
                step_start = 1'b1;
                state_next = S_WARM_WAIT;
            end
            S_WARM_WAIT:
            begin
                if (step_done)
                begin
                    first_next = step_z1;
                    // last TABLE_DEPTH warm-up steps fill the table top down
                    if (32'(cnt_reg) < 32'(clsr_pkg::TABLE_DEPTH))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[clsr_pkg::IDX_W-1:0];
                        ram_wdata = step_z1;
                    end
                    if (cnt_reg == '0)
                    begin
                        last_next  = step_z1;
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_WARM;
                    end
                end
            end
            S_DRAW:
            begin
                step_start    = 1'b1;
                div_start     = 1'b1;
                got_step_next = 1'b0;
                got_div_next  = 1'b0;
                state_next    = S_DRAW_WAIT;
            end
            S_DRAW_WAIT:
            begin
                if (step_done)
                begin
                    first_next    = step_z1;
                    second_next   = step_z2;
                    got_step_next = 1'b1;
                end
                if (div_done)
                begin
                    slot_next    = div_slot;
                    got_div_next = 1'b1;
                end
                if ((got_step_reg || step_done) && (got_div_reg || div_done))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                if (!out_valid_reg || rnd.ready)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = mix_val;
                    last_next      = mix_val;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= '0;
            second_reg    <= clsr_pkg::SECOND_INIT;
            last_reg      <= '0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            got_step_reg  <= 1'b0;
            got_div_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            got_step_reg  <= got_step_next;
            got_div_reg   <= got_div_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
        end
    end

    assign cmd.ready        = (state_reg == S_IDLE);
    assign rnd.valid        = out_valid_reg;
    assign rnd.random_value = out_value_reg;

    `ASSERT_NEVER(a_ram_rw_overlap, ram_we && ram_re, "table read and write in the same cycle")
    `ASSERT_ALWAYS(a_out_from_mix, $rose(out_valid_reg) |-> $past(state_reg == S_MIX), "result without table mix")
    `ASSERT_ALWAYS(a_mix_range, (state_reg == S_MIX) |-> (mix_val != 31'd0 && {1'b0, mix_val} < clsr_pkg::MOD1), "mixed value out of range")
    `ASSERT_ALWAYS(a_step_in_wait, step_done |-> (state_reg == S_WARM_WAIT || state_reg == S_DRAW_WAIT), "step result with nobody waiting")

endmodule

// ===== sim/combined_lcg_shuffle_rng_top_tb.sv =====
module combined_lcg_shuffle_rng_top_tb;

    localparam longint QUO1 = 53668;
    localparam longint REM1 = 12211;
    localparam longint QUO2 = 52774;
    localparam longint REM2 = 3791;
    localparam int RANDOM_ITEMS = 1930;
    localparam int SEED_PCT     = 3;
    localparam int MAX_PRINTS   = 40;

    class rng_scoreboard;
        bit [30:0] gen_a;
        bit [30:0] gen_b;
        bit [30:0] prev_out;
        bit [30:0] cells [clsr_pkg::TABLE_DEPTH];
        bit [30:0] expected_values [$];
        int errors;
        int n_draws;
        int n_seeds;
        int n_checked;

        function new();
            gen_a = '0;
            gen_b = clsr_pkg::SECOND_INIT;
            prev_out = '0;
            foreach (cells[i])
                cells[i] = '0;
            errors = 0;
            n_draws = 0;
            n_seeds = 0;
            n_checked = 0;
        endfunction

        // (a * z) mod m by Schrage's factorization
        function longint schrage_mod(longint z, longint a, longint q, longint r, longint m);
            longint k;
            longint t;
            k = z / q;
            t = a * (z - k * q) - k * r;
            if (t < 0)
                t += m;
            return t;
        endfunction

        function void warm_up(bit [30:0] s);
            longint v;
            v = (s == 0) ? 1 : longint'(s);
            gen_b = v[30:0];
            for (int i = clsr_pkg::TABLE_DEPTH + 7; i >= 0; i--)
            begin
                v = schrage_mod(v, clsr_pkg::MUL1, QUO1, REM1, clsr_pkg::MOD1);
                if (i < clsr_pkg::TABLE_DEPTH)
                    cells[i] = v[30:0];
            end
            gen_a = v[30:0];
            prev_out = cells[0];
        endfunction

        function void note_input(logic op, logic [30:0] seed);
            longint a;
            longint b;
            longint slot;
            longint diff;
            if (op == clsr_pkg::OP_SEED)
            begin
                warm_up(seed);
                n_seeds++;
            end
            else
            begin
                n_draws++;
                if (gen_a == 0)
                    warm_up(31'd1);
            end
            a = schrage_mod(gen_a, clsr_pkg::MUL1, QUO1, REM1, clsr_pkg::MOD1);
            b = schrage_mod(gen_b, clsr_pkg::MUL2, QUO2, REM2, clsr_pkg::MOD2);
            gen_a = a[30:0];
            gen_b = b[30:0];
            slot = longint'(prev_out) / longint'(clsr_pkg::SLOT_DIV);
            if (slot > clsr_pkg::TABLE_DEPTH - 1)
                slot = clsr_pkg::TABLE_DEPTH - 1;
            diff = longint'(cells[slot]) - b;
            cells[slot] = gen_a;
            if (diff < 1)
                diff += longint'(clsr_pkg::MOD1_LESS);
            prev_out = diff[30:0];
            expected_values.push_back(prev_out);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS)
                $display("mismatch @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [30:0] value);
            bit [30:0] want;
            if (expected_values.size() == 0)
            begin
                report_mismatch($sformatf("random_value %0d with no item pending", value));
                return;
            end
            want = expected_values.pop_front();
            n_checked++;
            if (value !== want)
                report_mismatch($sformatf("random_value %0d, want %0d", value, want));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;

    clsr_cmd_if cmd_bus ();
    clsr_rnd_if rnd_bus ();

    rng_scoreboard sb = new();

    combined_lcg_shuffle_rng_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rnd   (rnd_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #30000000;
        $display("[combined_lcg_shuffle_rng_top] ERROR");
        $finish;
    end

    initial
    begin
        rnd_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rnd_bus.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rnd_bus.valid && rnd_bus.ready)
                sb.check_result(rnd_bus.random_value);
            if (cmd_bus.valid && cmd_bus.ready)
                sb.note_input(cmd_bus.op, cmd_bus.seed_value);
        end
    end

    task send_item(logic op, logic [30:0] seed);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            cmd_bus.seed_value = 31'($urandom);
            @(negedge clk);
        end
        cmd_bus.valid = 1'b1;
        cmd_bus.op = op;
        cmd_bus.seed_value = seed;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    task drain_results();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        while (sb.expected_values.size() != 0)
            @(posedge clk);
    endtask

    function logic [30:0] pick_seed();
        case ($urandom_range(7))
            0: return 31'd0;
            1: return 31'd1;
            2: return 31'(clsr_pkg::MOD1);
            3: return 31'(clsr_pkg::MOD2);
            4: return 31'h7FFFFFFF;
            default: return 31'($urandom);
        endcase
    endfunction

    int send_pcts  [4] = '{0, 58, 0, 37};
    int stall_pcts [4] = '{0, 0, 58, 37};

    initial
    begin
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.op = clsr_pkg::OP_DRAW;
        cmd_bus.seed_value = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // draws before any seed start from an implicit seed of 1
        send_item(clsr_pkg::OP_DRAW, 31'h7FFFFFFF);
        send_item(clsr_pkg::OP_DRAW, 31'd0);
        send_item(clsr_pkg::OP_DRAW, 31'h2AAAAAAA);
        send_item(clsr_pkg::OP_SEED, 31'd0);
        send_item(clsr_pkg::OP_DRAW, 31'd0);
        send_item(clsr_pkg::OP_SEED, 31'd1);
        send_item(clsr_pkg::OP_SEED, 31'h7FFFFFFF);
        send_item(clsr_pkg::OP_DRAW, 31'h55555555);
        // first generator collapses to zero, next draw reseeds
        send_item(clsr_pkg::OP_SEED, 31'(clsr_pkg::MOD1));
        send_item(clsr_pkg::OP_DRAW, 31'd0);
        send_item(clsr_pkg::OP_DRAW, 31'd0);
        // second generator stuck at zero
        send_item(clsr_pkg::OP_SEED, 31'(clsr_pkg::MOD2));
        send_item(clsr_pkg::OP_DRAW, 31'd0);
        send_item(clsr_pkg::OP_DRAW, 31'd0);
        send_item(clsr_pkg::OP_DRAW, 31'd0);
        send_item(clsr_pkg::OP_SEED, 31'(clsr_pkg::MOD1_LESS));
        send_item(clsr_pkg::OP_SEED, 31'(clsr_pkg::MOD2) - 31'd1);
        send_item(clsr_pkg::OP_SEED, 31'h2AAAAAAA);
        send_item(clsr_pkg::OP_SEED, 31'h55555555);
        send_item(clsr_pkg::OP_DRAW, 31'h7FFFFFFF);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            begin
                if (i % 100 < 20)
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                else
                begin
                    send_idle_pct = send_pcts[ph];
                    stall_pct = stall_pcts[ph];
                end
                if ($urandom_range(99) < SEED_PCT)
                    send_item(clsr_pkg::OP_SEED, pick_seed());
                else
                    send_item(clsr_pkg::OP_DRAW, 31'($urandom));
            end
            drain_results();
            repeat ($urandom_range(5, 30)) @(posedge clk);
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain_results();
        repeat (200) @(posedge clk);

        $display("Checked %0d results: %0d draws, %0d reseeds, including seeds of 0,",
                 sb.n_checked, sb.n_draws, sb.n_seeds);
        $display("both moduli and all-ones, under four sender/receiver throttling mixes.");
        if (sb.errors == 0 && sb.expected_values.size() == 0)
            $display("[combined_lcg_shuffle_rng_top] OK");
        else
            $display("[combined_lcg_shuffle_rng_top] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/clsr_pkg.sv
hdl/clsr_if.sv
hdl/clsr_ram.sv
hdl/clsr_step.sv
hdl/clsr_div.sv
hdl/combined_lcg_shuffle_rng_top.sv
sim/combined_lcg_shuffle_rng_top_tb.sv
